### rtl/sha1_message_digest_unit_assert.svh
// ----------------------------------------------------------------------------
// SHA-1 digest unit assertion macros
// Concurrent property shorthands; expect clk and rst_n in the using scope.
// ----------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_DIGEST_UNIT_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SMDU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SMDU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sha1_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 digest unit package
// Shared command/status types, round constants and initial hash value.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1_pkg;

    localparam logic [31:0] K_CH   = 32'h5A827999;
    localparam logic [31:0] K_PAR1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_MAJ  = 32'h8F1BBCDC;
    localparam logic [31:0] K_PAR2 = 32'hCA62C1D6;

    localparam logic [31:0] SHA1_IV [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [7:0] PAD_BYTE      = 8'h80;
    localparam logic [5:0] FILL_LAST     = 6'd63;
    localparam logic [5:0] FILL_PAD_END  = 6'd56;
    localparam logic [6:0] ROUND_LAST    = 7'd79;
    localparam logic [2:0] LEN_IDX_FIRST = 3'd7;
    localparam logic [2:0] WORD_IDX_LAST = 3'd4;

    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_PAD,
        SRC_ZERO,
        SRC_LEN
    } byte_src_t;

    typedef enum logic [1:0] {
        GRP_CH,
        GRP_PAR1,
        GRP_MAJ,
        GRP_PAR2
    } round_grp_t;

    typedef struct packed {
        logic       push;
        byte_src_t  byte_sel;
        logic [2:0] len_idx;
        logic       load;
        logic       step;
        round_grp_t grp;
        logic       finish;
        logic       clear;
        logic [2:0] word_idx;
    } sha1_cmd_t;

    typedef struct packed {
        logic fill_last;
        logic fill_pad;
    } sha1_stat_t;

    function automatic round_grp_t round_grp(input logic [6:0] rnd);
        round_grp_t grp;
        priority if (rnd < 7'd20)
            grp = GRP_CH;
        else if (rnd < 7'd40)
            grp = GRP_PAR1;
        else if (rnd < 7'd60)
            grp = GRP_MAJ;
        else
            grp = GRP_PAR2;
        return grp;
    endfunction

endpackage

`default_nettype wire

### rtl/sha1_dp.sv
// ----------------------------------------------------------------------------
// SHA-1 datapath
// Byte packer, 16-word schedule shift line, round unit, chaining and length.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_dp
    import sha1_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire sha1_cmd_t   cmd,
    input  wire logic [7:0]  data_byte,
    output sha1_stat_t       stat,
    output logic [31:0]      digest_word
);

    logic [5:0]  fill_reg, fill_next;
    logic [63:0] len_reg, len_next;
    logic [31:0] chain_reg [5];
    logic [31:0] chain_next [5];
    logic [23:0] acc_reg, acc_next;
    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] a_next, b_next, c_next, d_next, e_next;

    logic [7:0]  byte_in;
    logic [31:0] sched_new;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic        word_done;

    always_comb
    begin
        unique case (cmd.byte_sel)
            SRC_DATA: byte_in = data_byte;
            SRC_PAD:  byte_in = PAD_BYTE;
            SRC_ZERO: byte_in = 8'h00;
            SRC_LEN:  byte_in = len_reg[{cmd.len_idx, 3'b000} +: 8];
            default:  byte_in = 8'h00;
        endcase
    end

    assign word_done = cmd.push && (fill_reg[1:0] == 2'b11);

    // W[t+16] from taps t+13, t+8, t+2 and t of the shift line
    always_comb
    begin
        logic [31:0] mix;
        mix = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        sched_new = {mix[30:0], mix[31]};
    end

    always_comb
    begin
        unique case (cmd.grp)
            GRP_CH:
            begin
                f_val = (b_reg & c_reg) | (~b_reg & d_reg);
                k_val = K_CH;
            end
            GRP_PAR1:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = K_PAR1;
            end
            GRP_MAJ:
            begin
                f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
                k_val = K_MAJ;
            end
            GRP_PAR2:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = K_PAR2;
            end
            default:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = K_PAR2;
            end
        endcase
    end

    always_comb
    begin
        fill_next = fill_reg;
        len_next  = len_reg;
        acc_next  = acc_reg;
        w_next    = w_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        c_next    = c_reg;
        d_next    = d_reg;
        e_next    = e_reg;
        chain_next = chain_reg;

        if (cmd.push)
        begin
            fill_next = fill_reg + 6'd1;
            acc_next  = {acc_reg[15:0], byte_in};
            if (cmd.byte_sel == SRC_DATA)
                len_next = len_reg + 64'd8;
        end

        // shift a completed big-endian word, or in a round the new schedule word, into the schedule line
        if (word_done || cmd.step)
        begin
            for (int i = 0; i < 15; i++)
                w_next[i] = w_reg[i + 1];
            w_next[15] = cmd.step ? sched_new : {acc_reg, byte_in};
        end

        if (cmd.load)
        begin
            a_next = chain_reg[0];
            b_next = chain_reg[1];
            c_next = chain_reg[2];
            d_next = chain_reg[3];
            e_next = chain_reg[4];
        end
        else if (cmd.step)
        begin
            a_next = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_reg[0];
            b_next = a_reg;
            c_next = {b_reg[1:0], b_reg[31:2]};
            d_next = c_reg;
            e_next = d_reg;
        end

        if (cmd.finish)
        begin
            chain_next[0] = chain_reg[0] + a_reg;
            chain_next[1] = chain_reg[1] + b_reg;
            chain_next[2] = chain_reg[2] + c_reg;
            chain_next[3] = chain_reg[3] + d_reg;
            chain_next[4] = chain_reg[4] + e_reg;
        end
        else if (cmd.clear)
        begin
            chain_next = SHA1_IV;
            len_next   = 64'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= 6'd0;
            len_reg   <= 64'd0;
            chain_reg <= SHA1_IV;
        end
        else
        begin
            fill_reg  <= fill_next;
            len_reg   <= len_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        w_reg   <= w_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
    end

    assign stat.fill_last = (fill_reg == FILL_LAST);
    assign stat.fill_pad  = (fill_reg == FILL_PAD_END);
    assign digest_word    = chain_reg[cmd.word_idx];

endmodule

`default_nettype wire

### rtl/sha1_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-1 controller
// Sequences byte intake, padding, the 80 rounds and digest output.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_ctrl
    import sha1_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic        s_axis_tuser,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [2:0]       m_axis_tuser,
    output logic             m_axis_tlast,
    input  wire sha1_stat_t  stat,
    output sha1_cmd_t        cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_ONE,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_LOAD,
        ST_ROUND,
        ST_FINISH,
        ST_OUT
    } state_t;

    state_t     state_reg, state_next;
    state_t     ret_reg, ret_next;
    logic [6:0] rnd_reg, rnd_next;
    logic [2:0] lidx_reg, lidx_next;
    logic [2:0] widx_reg, widx_next;

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        rnd_next   = rnd_reg;
        lidx_next  = lidx_reg;
        widx_next  = widx_reg;

        cmd          = '0;
        cmd.byte_sel = SRC_DATA;
        cmd.len_idx  = lidx_reg;
        cmd.grp      = round_grp(rnd_reg);
        cmd.word_idx = widx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.push = s_axis_tuser;
                    if (s_axis_tuser && stat.fill_last)
                    begin
                        state_next = ST_LOAD;
                        ret_next   = s_axis_tlast ? ST_PAD_ONE : ST_IDLE;
                    end
                    else if (s_axis_tlast)
                        state_next = ST_PAD_ONE;
                end
            end
            ST_PAD_ONE:
            begin
                cmd.push     = 1'b1;
                cmd.byte_sel = SRC_PAD;
                state_next   = stat.fill_last ? ST_LOAD : ST_PAD_ZERO;
                ret_next     = ST_PAD_ZERO;
            end
            ST_PAD_ZERO:
            begin
                if (stat.fill_pad)
                begin
                    state_next = ST_PAD_LEN;
                    lidx_next  = LEN_IDX_FIRST;
                end
                else
                begin
                    cmd.push     = 1'b1;
                    cmd.byte_sel = SRC_ZERO;
                    if (stat.fill_last)
                    begin
                        state_next = ST_LOAD;
                        ret_next   = ST_PAD_ZERO;
                    end
                end
            end
            ST_PAD_LEN:
            begin
                cmd.push     = 1'b1;
                cmd.byte_sel = SRC_LEN;
                lidx_next    = lidx_reg - 3'd1;
                if (stat.fill_last)
                begin
                    state_next = ST_LOAD;
                    ret_next   = ST_OUT;
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                rnd_next   = 7'd0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.step = 1'b1;
                if (rnd_reg == ROUND_LAST)
                    state_next = ST_FINISH;
                else
                    rnd_next = rnd_reg + 7'd1;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ret_reg;
                widx_next  = 3'd0;
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    if (widx_reg == WORD_IDX_LAST)
                    begin
                        cmd.clear  = 1'b1;
                        widx_next  = 3'd0;
                        state_next = ST_IDLE;
                    end
                    else
                        widx_next = widx_reg + 3'd1;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            rnd_reg   <= 7'd0;
            lidx_reg  <= 3'd0;
            widx_reg  <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            rnd_reg   <= rnd_next;
            lidx_reg  <= lidx_next;
            widx_reg  <= widx_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tuser  = widx_reg;
    assign m_axis_tlast  = (widx_reg == WORD_IDX_LAST);

endmodule

`default_nettype wire

### rtl/sha1_message_digest_unit.sv
// Bytes are taken one per cycle while idle; the 64th byte of a block starts a compression
// (load, 80 rounds at one per cycle, chaining add).
// End of message: padding plus one or two compressions, then five digest transfers,
// one per cycle while m_axis_tready is high.
// No byte is taken during padding or compression; there is a single round unit.
// Reset (rst_n low, asynchronous): initial hash value loaded, length and fill cleared.
// ----------------------------------------------------------------------------
// SHA-1 message digest unit
// Byte-stream SHA-1 engine with padding and five-word digest output.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_message_digest_unit
    import sha1_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] byte_valid
    input  wire logic        s_axis_tlast,   // message_end
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]       m_axis_tuser,   // [2:0] word_index
    output logic             m_axis_tlast    // last_word
);

    sha1_cmd_t  cmd;
    sha1_stat_t stat;

    sha1_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .stat          (stat),
        .cmd           (cmd)
    );

    sha1_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (s_axis_tdata),
        .stat        (stat),
        .digest_word (m_axis_tdata)
    );

endmodule

`default_nettype wire

### rtl/sha1_chk.sv
// ----------------------------------------------------------------------------
// SHA-1 digest unit checker
// Port-level properties of the digest unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sha1_message_digest_unit_assert.svh"

module sha1_chk
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic        s_axis_tlast,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [31:0] m_axis_tdata,
    input  wire logic [2:0]  m_axis_tuser,
    input  wire logic        m_axis_tlast
);

    // input side is closed while a digest is being delivered
    `SMDU_ASSERT_SAME(a_no_overlap, m_axis_tvalid, !s_axis_tready, "input open during digest output")

    // padding always takes time after the end marker
    `SMDU_ASSERT_NEXT(a_end_no_early, s_axis_tvalid && s_axis_tready && s_axis_tlast, !m_axis_tvalid, "digest too early after end transfer")

    // word index steps by one between digest transfers
    `SMDU_ASSERT_NEXT(a_word_step, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + 3'd1), "digest word index did not advance")

    // hold a stalled digest word
    `SMDU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled digest transfer changed")

endmodule

bind sha1_message_digest_unit sha1_chk u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
